@@ rtl/kevq_pkg.sv @@
// Shared types and codes for the key event queue.
// Used by kevq_cell and key_event_queue_dedup; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package kevq_pkg;

  localparam int unsigned KeyW    = 8;
  localparam int unsigned StatusW = 4;
  localparam int unsigned FillW   = 7;

  // Operation codes
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Status codes
  localparam logic [3:0] ST_QUEUED    = 4'd0;
  localparam logic [3:0] ST_IGNORED   = 4'd1;
  localparam logic [3:0] ST_SAME_KEY  = 4'd2;
  localparam logic [3:0] ST_OLD_PRESS = 4'd3;
  localparam logic [3:0] ST_OLD_EVENT = 4'd4;
  localparam logic [3:0] ST_NEW_DROP  = 4'd5;
  localparam logic [3:0] ST_POPPED    = 4'd6;
  localparam logic [3:0] ST_EMPTY     = 4'd7;
  localparam logic [3:0] ST_CLEARED   = 4'd8;

  typedef struct packed {
    logic [1:0]      mode;
    logic [KeyW-1:0] key_code;
    logic            is_press;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    event_key;
    logic               event_press;
    logic [FillW-1:0]   fill_count;
  } out_t;

  typedef struct packed {
    logic            press;
    logic [KeyW-1:0] key;
  } ent_t;

  // Per-cell update control
  typedef struct packed {
    logic shift;  // take the younger neighbor's entry
    logic load;   // take the new entry
    logic kill;   // mark empty
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/kevq_cell.sv @@
// One queue cell: holds one event and a running "press seen before" flag pair.
// Depends on kevq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kevq_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kevq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                nb_valid_i,
  input  wire kevq_pkg::ent_t      nb_ent_i,
  input  wire kevq_pkg::ent_t      new_ent_i,
  input  wire logic [kevq_pkg::KeyW-1:0] skey_i,
  input  wire logic                carry_k_i,
  input  wire logic                carry_a_i,
  output logic                     valid_o,
  output kevq_pkg::ent_t           ent_o,
  output logic                     carry_k_o,
  output logic                     carry_a_o
);

  logic           valid_q, valid_d;
  kevq_pkg::ent_t ent_q, ent_d;
  logic           pk_q, pa_q;
  logic           m_k, m_a;

  // Local matches: any press, and a press of the searched key
  assign m_a = valid_q & ent_q.press;
  assign m_k = m_a & (ent_q.key == skey_i);

  // Hand the flags on: set if this cell or an older one matched
  assign carry_k_o = pk_q | m_k;
  assign carry_a_o = pa_q | m_a;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (ctrl_i.kill) begin
      valid_d = 1'b0;
    end else if (ctrl_i.load) begin
      valid_d = 1'b1;
      ent_d   = new_ent_i;
    end else if (ctrl_i.shift) begin
      valid_d = nb_valid_i;
      ent_d   = nb_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pk_q    <= 1'b0;
      pa_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pk_q    <= carry_k_i;
      pa_q    <= carry_a_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign valid_o = valid_q;
  assign ent_o   = ent_q;

endmodule
`default_nettype wire

@@ rtl/key_event_queue_dedup.sv @@
// Top level of the key event queue with per-key down bits.
// Depends on kevq_pkg and kevq_cell.
`timescale 1ns / 1ps
`default_nettype none
// Keyboard event queue holding up to QUEUE_SLOTS-1 words in a row of cells, oldest
// in cell 0. Pops, clears, ignored pushes and pushes into a non-full queue complete
// straight from the idle state. A push into a full queue scans the row: the press flags
// ripple one cell per cycle in the scan state, and a resolve state then writes the
// result word. Removal compacts the row as the new word loads into the last cell.
// Results wait in an output register; the next word is taken once it is free or read.
module key_event_queue_dedup #(
  parameter int unsigned QUEUE_SLOTS = 128,
  parameter int unsigned KEY_CODES   = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire kevq_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output kevq_pkg::out_t       out_data_o
);

  localparam int unsigned N  = QUEUE_SLOTS - 1;
  localparam int unsigned CW = $clog2(QUEUE_SLOTS);
  localparam int unsigned KW = $clog2(KEY_CODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [KEY_CODES-1:0] down_q, down_d;
  kevq_pkg::ent_t      pend_q, pend_d;
  kevq_pkg::out_t      res_q, res_d;
  logic                ovalid_q, ovalid_d;

  kevq_pkg::cell_ctrl_t ctrl [N];
  logic                 cvalid [N];
  kevq_pkg::ent_t       cent [N];
  logic                 ck [N];
  logic                 ca [N];
  kevq_pkg::ent_t       new_ent;
  logic                 acc, tracked, dup;
  logic [KW-1:0]        kidx;

  // Row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic           nbv;
    kevq_pkg::ent_t nbe;
    logic           pki, pai;
    if (i == N - 1) begin : g_last
      assign nbv = 1'b0;
      assign nbe = '0;
    end else begin : g_mid
      assign nbv = cvalid[i+1];
      assign nbe = cent[i+1];
    end
    if (i == 0) begin : g_first
      assign pki = 1'b0;
      assign pai = 1'b0;
    end else begin : g_rest
      assign pki = ck[i-1];
      assign pai = ca[i-1];
    end
    kevq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[i]),
      .nb_valid_i (nbv),
      .nb_ent_i   (nbe),
      .new_ent_i  (new_ent),
      .skey_i     (pend_q.key),
      .carry_k_i  (pki),
      .carry_a_i  (pai),
      .valid_o    (cvalid[i]),
      .ent_o      (cent[i]),
      .carry_k_o  (ck[i]),
      .carry_a_o  (ca[i])
    );
  end

  assign in_ready_o = (state_q == S_IDLE) && (!ovalid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign kidx       = in_data_i.key_code[KW-1:0];
  assign tracked    = (32'(in_data_i.key_code) < KEY_CODES);
  assign dup        = tracked && (down_q[kidx] == in_data_i.is_press);
  assign new_ent    = (state_q == S_FIX) ? pend_q
                    : kevq_pkg::ent_t'{press: in_data_i.is_press, key: in_data_i.key_code};

  // Sequence the operations and build per-cell control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    scan_d   = scan_q;
    down_d   = down_q;
    pend_d   = pend_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && !out_ready_i;
    for (int i = 0; i < N; i++) begin
      ctrl[i] = '0;
    end
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          ovalid_d         = 1'b1;
          res_d            = '0;
          res_d.status     = kevq_pkg::ST_IGNORED;
          case (in_data_i.mode)
            kevq_pkg::MODE_PUSH: begin
              if (!dup) begin
                if (tracked) begin
                  down_d[kidx] = in_data_i.is_press;
                end
                if (count_q != CW'(N)) begin
                  for (int i = 0; i < N; i++) begin
                    ctrl[i].load = (CW'(i) == count_q);
                  end
                  count_d      = count_q + 1'b1;
                  res_d.status = kevq_pkg::ST_QUEUED;
                end else begin
                  ovalid_d = ovalid_q && !out_ready_i;
                  pend_d   = new_ent;
                  scan_d   = '0;
                  state_d  = S_SCAN;
                end
              end
            end
            kevq_pkg::MODE_POP: begin
              if (count_q == '0) begin
                res_d.status = kevq_pkg::ST_EMPTY;
              end else begin
                for (int i = 0; i < N; i++) begin
                  ctrl[i].shift = 1'b1;
                end
                res_d.event_key   = cent[0].key;
                res_d.event_press = cent[0].press;
                count_d           = count_q - 1'b1;
                res_d.status      = kevq_pkg::ST_POPPED;
              end
            end
            kevq_pkg::MODE_CLEAR: begin
              for (int i = 0; i < N; i++) begin
                ctrl[i].kill = 1'b1;
              end
              count_d      = '0;
              down_d       = '0;
              res_d.status = kevq_pkg::ST_CLEARED;
            end
            default: begin
              res_d.status = kevq_pkg::ST_IGNORED;
            end
          endcase
          res_d.fill_count = kevq_pkg::FillW'(count_d);
        end
      end
      S_SCAN: begin
        // Let the flags settle across the whole row
        if (scan_q == CW'(N - 1)) begin
          state_d = S_FIX;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_FIX: begin
        res_d            = '0;
        ovalid_d         = 1'b1;
        state_d          = S_IDLE;
        res_d.fill_count = kevq_pkg::FillW'(count_q);
        if (!pend_q.press && ck[N-1]) begin
          for (int i = 0; i < N; i++) begin
            ctrl[i].shift = ck[i];
          end
          ctrl[N-1].load = 1'b1;
          res_d.status   = kevq_pkg::ST_SAME_KEY;
        end else if (ca[N-1]) begin
          for (int i = 0; i < N; i++) begin
            ctrl[i].shift = ca[i];
          end
          ctrl[N-1].load = 1'b1;
          res_d.status   = kevq_pkg::ST_OLD_PRESS;
        end else if (pend_q.press) begin
          res_d.status = kevq_pkg::ST_NEW_DROP;
        end else begin
          for (int i = 0; i < N; i++) begin
            ctrl[i].shift = 1'b1;
          end
          ctrl[N-1].load = 1'b1;
          res_d.status   = kevq_pkg::ST_OLD_EVENT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      scan_q   <= '0;
      down_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      down_q   <= down_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;

endmodule
`default_nettype wire
